// ----- rtl/texture_sampler_bilinear_assert.svh -----
// Assertion macros shared by the texture sampler RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH
`define TEXTURE_SAMPLER_BILINEAR_ASSERT_SVH

`ifndef ASSERT_OFF

// The expression must hold at every clock edge outside reset.
`define TSB_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define TSB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`else

`define TSB_ASSERT(lbl, clk, rst_n, expr, msg)
`define TSB_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg)

`endif

`endif

// ----- rtl/tsb_pkg.sv -----
package tsb_pkg;

  // Default sizing of the texel map.
  localparam int DEF_MAX_SIDE   = 256;
  localparam int DEF_MAX_TEXELS = 65536;

  // Field widths fixed by the interface.
  localparam int SIDE_W  = 9;   // width and height registers
  localparam int CHAN_W  = 16;  // one color channel, 16-bit unorm
  localparam int TEXEL_W = 3 * CHAN_W;
  localparam int COORD_W = 32;  // signed Q16.16
  localparam int UNIT_W  = 17;  // wrapped coordinate, Q0.16 in 0..65536
  localparam int FRAC_W  = 16;
  localparam int POS_W   = UNIT_W + SIDE_W - 1;  // texel position, Q.16
  localparam int IDX_W   = 2 * SIDE_W;           // row * width + column
  localparam int WGT_W   = 2 * UNIT_W - 1;       // product of two axis weights
  localparam int MUL_A_W = UNIT_W;
  localparam int MUL_B_W = WGT_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = CHAN_W + 32;          // weights sum to 2^32

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TEX_HEIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WRAP_REPEAT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_NEAR = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_GRAY = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_8BIT = 3'd5;

  // Input word kinds.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Texel footprint along one axis.
  typedef struct packed {
    logic [SIDE_W-1:0] lo;
    logic [SIDE_W-1:0] hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  // Widen an 8-bit channel to 16-bit unorm (times 257), or pass 16 bits.
  function automatic logic [CHAN_W-1:0] widen(input logic [CHAN_W-1:0] v,
                                               input logic eight_bit);
    widen = eight_bit ? {v[7:0], v[7:0]} : v;
  endfunction

  // Wrap a Q16.16 coordinate into Q0.16: fractional part or clamp to [0,1].
  function automatic logic [UNIT_W-1:0] wrap_coord(input logic [COORD_W-1:0] raw,
                                                   input logic repeat_mode);
    logic [UNIT_W-1:0] res;
    res = raw[UNIT_W-1:0];
    if (repeat_mode) begin
      res = {1'b0, raw[FRAC_W-1:0]};
    end else if (raw[COORD_W-1]) begin
      res = '0;
    end else if (raw > 32'h0001_0000) begin
      res = 17'h1_0000;
    end
    wrap_coord = res;
  endfunction

  // Split a texel position into its two neighbors and the blend fraction.
  // Nearest filtering rounds to one texel and uses a zero fraction.
  function automatic axis_t axis_decode(input logic [POS_W-1:0] p,
                                        input logic nearest);
    axis_t             a;
    logic [POS_W:0]    rounded;
    rounded = {1'b0, p} + (POS_W + 1)'(17'h0_8000);
    if (nearest) begin
      a.lo   = rounded[FRAC_W +: SIDE_W];
      a.frac = '0;
    end else begin
      a.lo   = p[FRAC_W +: SIDE_W];
      a.frac = p[FRAC_W-1:0];
    end
    a.hi = a.lo + SIDE_W'(a.frac != '0);
    axis_decode = a;
  endfunction

endpackage

// ----- rtl/texture_sampler_bilinear.sv -----
// Bilinear / nearest texture sampler over an on-chip texel map. A word with
// tuser = 0 writes one texel (widened from 8 bits and replicated from gray as
// configured) in the cycle it is accepted and returns nothing. A word with
// tuser = 1 samples at Q16.16 coordinates (s, t) and returns one RGB word of
// 16-bit unorm channels. All multiplications run on one shared 17 x 33 bit
// multiplier stepped by a small sequencer, and the texel map has a single
// port, so a sample occupies the block from acceptance to the next ready:
// one corner with nearest filtering and four with bilinear filtering, each
// corner stepped through weight, read and three channel products, plus any
// wait for an earlier result still in the output register. Writes are taken
// only while no sample is in flight. The texel map is not cleared at
// reset: sample only texels that were written. Configuration must be
// written while no sample is in flight.
`include "texture_sampler_bilinear_assert.svh"

module texture_sampler_bilinear
  import tsb_pkg::*;
#(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int MAX_TEXELS = DEF_MAX_TEXELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input words.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: texel_index, in_red, in_green, in_blue, coord_s, coord_t
  input  logic [127:0]          in_tdata,
  // tuser: func
  input  logic                  in_tuser,
  // Result words.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: out_red, out_green, out_blue
  output logic [47:0]           out_tdata,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SIDE_W-1:0]     cfg_wdata
);

  localparam int AW       = $clog2(MAX_TEXELS);
  localparam int SIDE_CAP = (MAX_SIDE > 511) ? 511 : MAX_SIDE;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PX   = 4'd1;
  localparam logic [3:0] S_PY   = 4'd2;
  localparam logic [3:0] S_ROW  = 4'd3;
  localparam logic [3:0] S_RLO  = 4'd4;
  localparam logic [3:0] S_RHI  = 4'd5;
  localparam logic [3:0] S_WGT  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_M0   = 4'd8;
  localparam logic [3:0] S_M1   = 4'd9;
  localparam logic [3:0] S_M2   = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Configuration registers.
  logic [SIDE_W-1:0] tex_width_r, tex_height_r;
  logic              wrap_repeat_r, filter_nearest_r, source_gray_r, source_8bit_r;

  // Sequencer and datapath registers.
  logic [3:0]         state_r, state_nxt;
  logic [1:0]         corner_r, corner_nxt;
  logic [UNIT_W-1:0]  us_r, ut_r;
  axis_t              ax_r, ay_r;
  logic [IDX_W-1:0]   rlo_r, rhi_r;
  logic [WGT_W-1:0]   wgt_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [1:0]         pend_ch_r, pend_ch_nxt;
  logic [ACC_W-1:0]   acc_r [3];
  logic [TEXEL_W-1:0] mem_q_r;
  logic               oob_r;
  logic               out_tvalid_r;
  logic [47:0]        out_tdata_r;

  // Input word fields.
  logic [15:0]        texel_index;
  logic [CHAN_W-1:0]  in_red, in_green, in_blue;
  logic [COORD_W-1:0] coord_s, coord_t;
  logic               in_acc;

  assign texel_index = in_tdata[15:0];
  assign in_red      = in_tdata[31:16];
  assign in_green    = in_tdata[47:32];
  assign in_blue     = in_tdata[63:48];
  assign coord_s     = in_tdata[95:64];
  assign coord_t     = in_tdata[127:96];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r      <= SIDE_W'(1);
      tex_height_r     <= SIDE_W'(1);
      wrap_repeat_r    <= 1'b1;
      filter_nearest_r <= 1'b1;
      source_gray_r    <= 1'b0;
      source_8bit_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEX_WIDTH:   tex_width_r      <= cfg_wdata;
        REG_TEX_HEIGHT:  tex_height_r     <= cfg_wdata;
        REG_WRAP_REPEAT: wrap_repeat_r    <= cfg_wdata[0];
        REG_FILTER_NEAR: filter_nearest_r <= cfg_wdata[0];
        REG_SOURCE_GRAY: source_gray_r    <= cfg_wdata[0];
        REG_SOURCE_8BIT: source_8bit_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective texture sides: zero acts as one, large values saturate.
  logic [SIDE_W-1:0] side_w, side_h;

  always_comb begin
    side_w = tex_width_r;
    if (tex_width_r == '0) begin
      side_w = SIDE_W'(1);
    end else if (32'(tex_width_r) > MAX_SIDE) begin
      side_w = SIDE_W'(SIDE_CAP);
    end
    side_h = tex_height_r;
    if (tex_height_r == '0) begin
      side_h = SIDE_W'(1);
    end else if (32'(tex_height_r) > MAX_SIDE) begin
      side_h = SIDE_W'(SIDE_CAP);
    end
  end

  // Texel write data, widened and replicated as configured.
  logic [CHAN_W-1:0]  wr_red;
  logic [TEXEL_W-1:0] wr_texel;
  logic               mem_we;

  assign wr_red   = widen(in_red, source_8bit_r);
  assign wr_texel = source_gray_r ? {wr_red, wr_red, wr_red}
                                  : {widen(in_blue, source_8bit_r),
                                     widen(in_green, source_8bit_r), wr_red};
  assign mem_we   = in_acc && (in_tuser == FUNC_WRITE) && (32'(texel_index) < MAX_TEXELS);

  // Read address of the current corner; indexes past the map read as zero.
  logic [IDX_W-1:0] rd_idx;
  logic             rd_oob;
  logic [AW-1:0]    mem_addr;

  assign rd_idx   = (corner_r[1] ? rhi_r : rlo_r)
                  + IDX_W'(corner_r[0] ? ax_r.hi : ax_r.lo);
  assign rd_oob   = (32'(rd_idx) >= MAX_TEXELS);
  assign mem_addr = (state_r == S_IDLE) ? AW'(32'(texel_index)) : AW'(32'(rd_idx));

  // Single-port texel map with registered read.
  logic [TEXEL_W-1:0] texel_mem [MAX_TEXELS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      texel_mem[mem_addr] <= wr_texel;
    end
    if (state_r == S_RD) begin
      mem_q_r <= texel_mem[mem_addr];
      oob_r   <= rd_oob;
    end
  end

  // Channel of the fetched texel that feeds the multiplier.
  logic [CHAN_W-1:0] chan;

  always_comb begin
    case (state_r)
      S_M1:    chan = mem_q_r[CHAN_W +: CHAN_W];
      S_M2:    chan = mem_q_r[2*CHAN_W +: CHAN_W];
      default: chan = mem_q_r[0 +: CHAN_W];
    endcase
    if (oob_r) begin
      chan = '0;
    end
  end

  // Corner weights along each axis.
  logic [UNIT_W-1:0] wx, wy;

  assign wx = corner_r[0] ? {1'b0, ax_r.frac} : (UNIT_W'(17'h1_0000) - {1'b0, ax_r.frac});
  assign wy = corner_r[1] ? {1'b0, ay_r.frac} : (UNIT_W'(17'h1_0000) - {1'b0, ay_r.frac});

  // Shared multiplier: operand selection per sequencer step.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_PX: begin
        mul_a = us_r;
        mul_b = MUL_B_W'(side_w - SIDE_W'(1));
      end
      S_PY: begin
        mul_a = ut_r;
        mul_b = MUL_B_W'(side_h - SIDE_W'(1));
      end
      S_RLO: begin
        mul_a = MUL_A_W'(ay_r.lo);
        mul_b = MUL_B_W'(side_w);
      end
      S_RHI: begin
        mul_a = MUL_A_W'(ay_r.hi);
        mul_b = MUL_B_W'(side_w);
      end
      S_WGT: begin
        mul_a = wx;
        mul_b = MUL_B_W'(wy);
      end
      S_M0, S_M1, S_M2: begin
        mul_a = MUL_A_W'(chan);
        mul_b = wgt_r;
      end
      default: ;
    endcase
    prod_nxt = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  // Sequencer next state and product bookkeeping.
  always_comb begin
    state_nxt    = state_r;
    corner_nxt   = corner_r;
    pend_vld_nxt = 1'b0;
    pend_ch_nxt  = pend_ch_r;
    case (state_r)
      S_IDLE: begin
        corner_nxt = '0;
        if (in_acc && (in_tuser == FUNC_SAMPLE)) begin
          state_nxt = S_PX;
        end
      end
      S_PX:  state_nxt = S_PY;
      S_PY:  state_nxt = S_ROW;
      S_ROW: state_nxt = S_RLO;
      S_RLO: state_nxt = S_RHI;
      S_RHI: state_nxt = S_WGT;
      S_WGT: state_nxt = S_RD;
      S_RD:  state_nxt = S_M0;
      S_M0: begin
        state_nxt    = S_M1;
        pend_vld_nxt = 1'b1;
        pend_ch_nxt  = 2'd0;
      end
      S_M1: begin
        state_nxt    = S_M2;
        pend_vld_nxt = 1'b1;
        pend_ch_nxt  = 2'd1;
      end
      S_M2: begin
        pend_vld_nxt = 1'b1;
        pend_ch_nxt  = 2'd2;
        if (filter_nearest_r || (corner_r == 2'd3)) begin
          state_nxt = S_FIN;
        end else begin
          corner_nxt = corner_r + 2'd1;
          state_nxt  = S_WGT;
        end
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      corner_r   <= '0;
      pend_vld_r <= 1'b0;
      pend_ch_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      corner_r   <= corner_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_ch_r  <= pend_ch_nxt;
    end
  end

  // Datapath registers: coordinates, footprint, row bases, weight, product.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_acc) begin
      us_r <= wrap_coord(coord_s, wrap_repeat_r);
      ut_r <= wrap_coord(coord_t, wrap_repeat_r);
    end
    if (state_r == S_PY) begin
      ax_r <= axis_decode(prod_r[POS_W-1:0], filter_nearest_r);
    end
    if (state_r == S_ROW) begin
      ay_r <= axis_decode(prod_r[POS_W-1:0], filter_nearest_r);
    end
    if (state_r == S_RHI) begin
      rlo_r <= prod_r[IDX_W-1:0];
    end
    if ((state_r == S_WGT) && (corner_r == 2'd0)) begin
      rhi_r <= prod_r[IDX_W-1:0];
    end
    if (state_r == S_RD) begin
      wgt_r <= prod_r[WGT_W-1:0];
    end
  end

  // Channel accumulators: each product passes through prod_r before it is added.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
      acc_r[2] <= '0;
    end else if (pend_vld_r) begin
      case (pend_ch_r)
        2'd0:    acc_r[0] <= acc_r[0] + prod_r[ACC_W-1:0];
        2'd1:    acc_r[1] <= acc_r[1] + prod_r[ACC_W-1:0];
        default: acc_r[2] <= acc_r[2] + prod_r[ACC_W-1:0];
      endcase
    end
  end

  // Round the blended sums to 16-bit unorm.
  logic [ACC_W-1:0] rnd0, rnd1, rnd2;

  assign rnd0 = acc_r[0] + ACC_W'(33'h0_8000_0000);
  assign rnd1 = acc_r[1] + ACC_W'(33'h0_8000_0000);
  assign rnd2 = acc_r[2] + ACC_W'(33'h0_8000_0000);

  // Output register; holds a word until the consumer takes it.
  logic out_load;

  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {rnd2[ACC_W-1 -: CHAN_W], rnd1[ACC_W-1 -: CHAN_W],
                      rnd0[ACC_W-1 -: CHAN_W]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks on the sequencer.
  `TSB_ASSERT(a_no_write_busy, clk, rst_n, (state_r == S_IDLE) || !mem_we, "texel write while sampling")
  `TSB_ASSERT_NEXT(a_pend_after_mul, clk, rst_n, (state_r == S_M0) || (state_r == S_M1) || (state_r == S_M2), pend_vld_r, "channel product not accumulated")
  `TSB_ASSERT(a_nearest_one_corner, clk, rst_n, !(filter_nearest_r && (state_r == S_M2)) || (corner_r == 2'd0), "nearest sample visited more than one corner")
  `TSB_ASSERT_NEXT(a_out_wait, clk, rst_n, (state_r == S_OUT) && out_tvalid_r && !out_tready, (state_r == S_OUT), "result overwrote a waiting word")

endmodule
